// ===== rtl/core/bsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared sizes, codes, state type and control structs of the Banker's safety check unit.
package bsc_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int BSC_MAX_PROCS   = 16;
    localparam int BSC_MAX_RES     = 16;
    localparam int BSC_COUNT_WIDTH = 16;

    // Fixed field widths of the stream and configuration ports.
    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int AMOUNT_W   = 16;
    localparam int PROC_OUT_W = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes and their reset value.
    localparam logic [CFG_IDX_W-1:0]  CFG_NUM_PROCS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_NUM_RES     = 2'd1;
    localparam logic [CFG_DATA_W-1:0] CFG_COUNT_RESET = 5'd16;

    // Kind of an input transaction.
    typedef enum logic [1:0] {
        ACT_LOAD_ALLOC = 2'd0,
        ACT_LOAD_CLAIM = 2'd1,
        ACT_LOAD_AVAIL = 2'd2,
        ACT_RUN        = 2'd3
    } t_bsc_action;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_PROC,
        ST_CHK_RD,
        ST_CHK_CMP,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_EMIT
    } t_bsc_state;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic init;
        logic pass_restart;
        logic proc_next;
        logic res_clear;
        logic res_next;
        logic work_add;
        logic proc_commit;
        logic set_unsafe;
        logic emit_start;
        logic emit_load;
    } t_bsc_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_run;
        logic p_end;
        logic p_done;
        logic seq_full;
        logic found;
        logic need_fits;
        logic r_last;
        logic out_free;
        logic emit_last;
        logic unsafe;
    } t_bsc_stat;

endpackage

// ===== rtl/core/bsc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the safety check: loads, scan passes, fit test, release and result output.
module bsc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bsc_pkg::t_bsc_stat i_stat,
    output bsc_pkg::t_bsc_cmd  o_cmd,
    output logic               o_in_ready
);
    import bsc_pkg::*;

    t_bsc_state r_state;
    t_bsc_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_stat.in_run) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_state = ST_PROC;
            end
            ST_PROC: begin
                if (i_stat.p_end) begin
                    if (i_stat.seq_full || !i_stat.found) begin
                        n_state = ST_EMIT;
                    end
                end else if (!i_stat.p_done) begin
                    n_state = ST_CHK_RD;
                end
            end
            ST_CHK_RD: begin
                n_state = ST_CHK_CMP;
            end
            ST_CHK_CMP: begin
                if (!i_stat.need_fits) begin
                    n_state = ST_PROC;
                end else if (i_stat.r_last) begin
                    n_state = ST_ADD_RD;
                end else begin
                    n_state = ST_CHK_RD;
                end
            end
            ST_ADD_RD: begin
                n_state = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                n_state = i_stat.r_last ? ST_PROC : ST_ADD_RD;
            end
            ST_EMIT: begin
                if (i_stat.out_free && (i_stat.unsafe || i_stat.emit_last)) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && !i_stat.in_run;
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
            end
            ST_PROC: begin
                if (i_stat.p_end) begin
                    if (i_stat.seq_full) begin
                        o_cmd.emit_start = 1'b1;
                    end else if (!i_stat.found) begin
                        o_cmd.emit_start = 1'b1;
                        o_cmd.set_unsafe = 1'b1;
                    end else begin
                        o_cmd.pass_restart = 1'b1;
                    end
                end else if (i_stat.p_done) begin
                    o_cmd.proc_next = 1'b1;
                end else begin
                    o_cmd.res_clear = 1'b1;
                end
            end
            ST_CHK_RD: begin
            end
            ST_CHK_CMP: begin
                if (!i_stat.need_fits) begin
                    o_cmd.proc_next = 1'b1;
                end else if (i_stat.r_last) begin
                    o_cmd.res_clear = 1'b1;
                end else begin
                    o_cmd.res_next = 1'b1;
                end
            end
            ST_ADD_RD: begin
            end
            ST_ADD_WR: begin
                o_cmd.work_add = 1'b1;
                if (i_stat.r_last) begin
                    o_cmd.proc_commit = 1'b1;
                end else begin
                    o_cmd.res_next = 1'b1;
                end
            end
            ST_EMIT: begin
                o_cmd.emit_load = i_stat.out_free;
            end
        endcase
    end

endmodule

// ===== rtl/core/bsc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the safety check: matrix memories, work vector, finish marks, sequence and output register.
module bsc_datapath #(
    parameter int MAX_PROCS   = bsc_pkg::BSC_MAX_PROCS,
    parameter int MAX_RES     = bsc_pkg::BSC_MAX_RES,
    parameter int COUNT_WIDTH = bsc_pkg::BSC_COUNT_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bsc_pkg::t_bsc_cmd                i_cmd,
    output bsc_pkg::t_bsc_stat               o_stat,
    input  bsc_pkg::t_bsc_action             i_action,
    input  logic [bsc_pkg::ROW_W-1:0]        i_proc_row,
    input  logic [bsc_pkg::COL_W-1:0]        i_res_col,
    input  logic [bsc_pkg::AMOUNT_W-1:0]     i_amount,
    input  logic                             i_cfg_valid,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [bsc_pkg::PROC_OUT_W-1:0]   o_out_proc,
    output logic                             o_out_safe,
    output logic                             o_out_last
);
    import bsc_pkg::*;

    localparam int PW    = $clog2(MAX_PROCS);
    localparam int RW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int PCW   = $clog2(MAX_PROCS + 1);
    localparam int RCW   = $clog2(MAX_RES + 1);
    localparam int WW    = COUNT_WIDTH + 5;
    localparam int AW    = PW + RW;
    localparam int DEPTH = 1 << AW;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_cfg_np;
    logic [CFG_DATA_W-1:0] r_cfg_nr;

    // Scan control.
    logic [PCW-1:0]       r_p;
    logic [RCW-1:0]       r_r;
    logic [PCW-1:0]       r_seq_cnt;
    logic [PCW-1:0]       r_out_k;
    logic [MAX_PROCS-1:0] r_done;
    logic                 r_found;
    logic                 r_unsafe;
    logic                 r_out_valid;

    // Storage and payload.
    logic [COUNT_WIDTH-1:0] r_alloc_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_claim_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_alloc_q;
    logic [COUNT_WIDTH-1:0] r_claim_q;
    logic [COUNT_WIDTH-1:0] r_avail [MAX_RES];
    logic [WW-1:0]          r_work [MAX_RES];
    logic [PW-1:0]          r_seq [MAX_PROCS];
    logic [PROC_OUT_W-1:0]  r_out_proc;
    logic                   r_out_safe;
    logic                   r_out_last;

    logic [PCW-1:0]         w_np;
    logic [RCW-1:0]         w_nr;
    logic [PW+ROW_W-1:0]    w_row_ext;
    logic [RW+COL_W-1:0]    w_col_ext;
    logic                   w_row_ok;
    logic                   w_col_ok;
    logic [AW-1:0]          w_wr_addr;
    logic [AW-1:0]          w_rd_addr;
    logic [COUNT_WIDTH-1:0] w_amount;
    logic [PW-1:0]          w_pidx;
    logic [RW-1:0]          w_ridx;
    logic [COUNT_WIDTH:0]   w_need;
    logic                   w_fits;
    logic                   w_emit_last;

    // Counts in use: zero acts as one, anything above the maximum saturates.
    always_comb begin
        priority if (r_cfg_np == '0) begin
            w_np = PCW'(1);
        end else if (32'(r_cfg_np) > MAX_PROCS) begin
            w_np = PCW'(MAX_PROCS);
        end else begin
            w_np = PCW'(r_cfg_np);
        end
        priority if (r_cfg_nr == '0) begin
            w_nr = RCW'(1);
        end else if (32'(r_cfg_nr) > MAX_RES) begin
            w_nr = RCW'(MAX_RES);
        end else begin
            w_nr = RCW'(r_cfg_nr);
        end
    end

    // Load addressing; rows and columns outside the array are dropped.
    assign w_row_ext = (PW + ROW_W)'(i_proc_row);
    assign w_col_ext = (RW + COL_W)'(i_res_col);
    assign w_row_ok  = 32'(i_proc_row) < MAX_PROCS;
    assign w_col_ok  = 32'(i_res_col) < MAX_RES;
    assign w_wr_addr = {w_row_ext[PW-1:0], w_col_ext[RW-1:0]};
    assign w_amount  = COUNT_WIDTH'(i_amount);

    assign w_pidx    = r_p[PW-1:0];
    assign w_ridx    = r_r[RW-1:0];
    assign w_rd_addr = {w_pidx, w_ridx};

    // Allocation matrix: one write port for loads, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_row_ok && w_col_ok && (i_action == ACT_LOAD_ALLOC)) begin
            r_alloc_mem[w_wr_addr] <= w_amount;
        end
        r_alloc_q <= r_alloc_mem[w_rd_addr];
    end

    // Maximum-claim matrix, organized the same way.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_row_ok && w_col_ok && (i_action == ACT_LOAD_CLAIM)) begin
            r_claim_mem[w_wr_addr] <= w_amount;
        end
        r_claim_q <= r_claim_mem[w_rd_addr];
    end

    // Fit test: a negative need always fits, otherwise it must not exceed the work count.
    assign w_need = {1'b0, r_claim_q} - {1'b0, r_alloc_q};
    assign w_fits = w_need[COUNT_WIDTH] || (WW'(w_need[COUNT_WIDTH-1:0]) <= r_work[w_ridx]);

    assign w_emit_last = (r_out_k == (w_np - 1'b1));

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_np    <= CFG_COUNT_RESET;
            r_cfg_nr    <= CFG_COUNT_RESET;
            r_p         <= '0;
            r_r         <= '0;
            r_seq_cnt   <= '0;
            r_out_k     <= '0;
            r_done      <= '0;
            r_found     <= 1'b0;
            r_unsafe    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_NUM_PROCS)) begin
                r_cfg_np <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_NUM_RES)) begin
                r_cfg_nr <= i_cfg_data;
            end
            if (i_cmd.init) begin
                r_p       <= '0;
                r_r       <= '0;
                r_seq_cnt <= '0;
                r_done    <= '0;
                r_found   <= 1'b0;
                r_unsafe  <= 1'b0;
            end
            if (i_cmd.pass_restart) begin
                r_p     <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.proc_next) begin
                r_p <= r_p + 1'b1;
            end
            if (i_cmd.res_clear) begin
                r_r <= '0;
            end
            if (i_cmd.res_next) begin
                r_r <= r_r + 1'b1;
            end
            // A process that fits is finished and recorded in the sequence.
            if (i_cmd.proc_commit) begin
                r_done[w_pidx] <= 1'b1;
                r_seq_cnt      <= r_seq_cnt + 1'b1;
                r_found        <= 1'b1;
                r_p            <= r_p + 1'b1;
            end
            if (i_cmd.set_unsafe) begin
                r_unsafe <= 1'b1;
            end
            if (i_cmd.emit_start) begin
                r_out_k <= '0;
            end
            // Output register: loaded by the sequencer, emptied by the sink.
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
                r_out_k     <= r_out_k + 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: available vector, work vector, sequence and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_col_ok && (i_action == ACT_LOAD_AVAIL)) begin
            r_avail[w_col_ext[RW-1:0]] <= w_amount;
        end
        if (i_cmd.init) begin
            for (int i = 0; i < MAX_RES; i++) begin
                r_work[i] <= WW'(r_avail[i]);
            end
        end
        if (i_cmd.work_add) begin
            r_work[w_ridx] <= r_work[w_ridx] + WW'(r_alloc_q);
        end
        if (i_cmd.proc_commit) begin
            r_seq[r_seq_cnt[PW-1:0]] <= w_pidx;
        end
        if (i_cmd.emit_load) begin
            if (r_unsafe) begin
                r_out_proc <= '0;
                r_out_safe <= 1'b0;
                r_out_last <= 1'b1;
            end else begin
                r_out_proc <= PROC_OUT_W'(r_seq[r_out_k[PW-1:0]]);
                r_out_safe <= 1'b1;
                r_out_last <= w_emit_last;
            end
        end
    end

    // Status toward the sequencer.
    always_comb begin
        o_stat.in_run    = (i_action == ACT_RUN);
        o_stat.p_end     = (r_p == w_np);
        o_stat.p_done    = r_done[w_pidx];
        o_stat.seq_full  = (r_seq_cnt == w_np);
        o_stat.found     = r_found;
        o_stat.need_fits = w_fits;
        o_stat.r_last    = (r_r == (w_nr - 1'b1));
        o_stat.out_free  = !r_out_valid || i_out_ready;
        o_stat.emit_last = w_emit_last;
        o_stat.unsafe    = r_unsafe;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_proc  = r_out_proc;
    assign o_out_safe  = r_out_safe;
    assign o_out_last  = r_out_last;

endmodule

// ===== rtl/core/bankers_safety_check_unit.sv =====
`timescale 1ns / 1ps
// Top level of the Banker's safety check unit: stream ports, sequencer and datapath.

// Load transactions (allocation, maximum claim or available entry) are taken one per cycle
// and produce no result. A run transaction is taken at once and then stalls the input until
// its last result has been loaded into the output register. The check has a setup state and
// then runs scan passes in process index order: each unfinished process gets a fit test that
// reads and then compares each resource in turn, a process that fits reads and then writes
// back each resource it releases, and each pass ends with a check for progress. There are up
// to num_processes passes, and the single read port of the matrix memories serves one
// resource at a time. The results then leave one per cycle while the sink is ready, through
// an output register: the safe sequence with the final index marked by tlast, or a single
// unsafe result with tuser low. Load items are accepted while a last result still waits in
// that register. The matrices are not cleared after reset; every entry in use must be loaded
// before a run.
module bankers_safety_check_unit #(
    parameter int MAX_PROCS   = bsc_pkg::BSC_MAX_PROCS,
    parameter int MAX_RES     = bsc_pkg::BSC_MAX_RES,
    parameter int COUNT_WIDTH = bsc_pkg::BSC_COUNT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bsc_pkg::IN_DATA_W-1:0]     s_tdata,   // proc_row[3:0], res_col[7:4], amount[23:8]
    input  logic [1:0]                        s_tuser,   // action[1:0]
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bsc_pkg::OUT_DATA_W-1:0]    m_tdata,   // proc_index[3:0], zero[7:4]
    output logic                              m_tuser,   // is_safe[0]
    output logic                              m_tlast,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bsc_pkg::*;

    t_bsc_cmd              w_cmd;
    t_bsc_stat             w_stat;
    logic [PROC_OUT_W-1:0] w_out_proc;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    bsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (s_tready)
    );

    bsc_datapath #(
        .MAX_PROCS   (MAX_PROCS),
        .MAX_RES     (MAX_RES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_action    (t_bsc_action'(s_tuser)),
        .i_proc_row  (s_tdata[3:0]),
        .i_res_col   (s_tdata[7:4]),
        .i_amount    (s_tdata[23:8]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_out_proc  (w_out_proc),
        .o_out_safe  (m_tuser),
        .o_out_last  (m_tlast)
    );

    assign m_tdata = OUT_DATA_W'(w_out_proc);

    // An unsafe result stands alone: index zero and marked last.
    a_unsafe_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("unsafe result not a lone zero-index last transaction");

    // A result is never written over one that the sink has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while still pending");

    // A process is finished at most once per run.
    a_finish_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.proc_commit |-> !w_stat.p_done)
        else $error("process finished twice in one run");

    // The input is stalled right after the setup of a run.
    a_stall_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.init |=> !s_tready)
        else $error("input accepted during a running check");

endmodule

// ===== tb/bsc_result_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts and compares the results of the Banker's safety check unit.
module bsc_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bsc_pkg::IN_DATA_W-1:0]  s_tdata,   // proc_row[3:0], res_col[7:4], amount[23:8]
    input  logic [1:0]                     s_tuser,   // action[1:0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bsc_pkg::OUT_DATA_W-1:0] m_tdata,   // proc_index[3:0], zero[7:4]
    input  logic                           m_tuser,   // is_safe[0]
    input  logic                           m_tlast,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);
    import bsc_pkg::*;

    localparam int NPROC  = BSC_MAX_PROCS;
    localparam int NRES   = BSC_MAX_RES;
    localparam int WORK_W = BSC_COUNT_WIDTH + 5;

    typedef struct packed {
        logic [PROC_OUT_W-1:0] proc_index;
        logic                  is_safe;
        logic                  last;
    } t_seq_result;

    logic [AMOUNT_W-1:0]   alloc_mem [NPROC][NRES];
    logic [AMOUNT_W-1:0]   claim_mem [NPROC][NRES];
    logic [AMOUNT_W-1:0]   avail_mem [NRES];
    logic [CFG_DATA_W-1:0] procs_cfg;
    logic [CFG_DATA_W-1:0] res_cfg;
    t_seq_result           result_q [$];

    // A count of zero behaves as one; a count above the array size saturates.
    function automatic int count_in_use(logic [CFG_DATA_W-1:0] raw, int limit);
        if (raw == '0) return 1;
        return (int'(raw) > limit) ? limit : int'(raw);
    endfunction

    // Runs the safety scan on the loaded state and queues the results it yields.
    function automatic void predict_safety();
        int                np;
        int                nr;
        int                placed;
        int                need;
        bit                fits;
        bit                progress;
        bit                finished [NPROC];
        logic [WORK_W-1:0] work [NRES];
        logic [3:0]        order [NPROC];
        np = count_in_use(procs_cfg, NPROC);
        nr = count_in_use(res_cfg, NRES);
        placed = 0;
        for (int r = 0; r < nr; r++) work[r] = WORK_W'(avail_mem[r]);
        for (int p = 0; p < NPROC; p++) finished[p] = 1'b0;
        while (placed < np) begin
            progress = 1'b0;
            // One pass in index order; a finished process releases at once.
            for (int p = 0; p < np; p++) begin
                if (!finished[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < nr; r++) begin
                        need = int'(claim_mem[p][r]) - int'(alloc_mem[p][r]);
                        if (need > int'(work[r])) fits = 1'b0;
                    end
                    if (fits) begin
                        for (int r = 0; r < nr; r++) begin
                            work[r] = work[r] + WORK_W'(alloc_mem[p][r]);
                        end
                        order[placed] = 4'(p);
                        placed++;
                        finished[p] = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
            if (!progress) begin
                result_q.push_back('{proc_index: '0, is_safe: 1'b0, last: 1'b1});
                return;
            end
        end
        for (int k = 0; k < np; k++) result_q.push_back('{order[k], 1'b1, k == np - 1});
    endfunction

    always @(posedge i_clk) begin
        logic [ROW_W-1:0]    ld_row;
        logic [COL_W-1:0]    ld_col;
        logic [AMOUNT_W-1:0] ld_amount;
        t_seq_result         want;
        if (!i_rst_n) begin
            procs_cfg = CFG_COUNT_RESET;
            res_cfg   = CFG_COUNT_RESET;
            result_q.delete();
        end else begin
            // Register writes; indexes past the register list change nothing.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUM_PROCS: procs_cfg = i_cfg_data;
                    CFG_NUM_RES:   res_cfg   = i_cfg_data;
                    default: ;
                endcase
            end
            // Input transaction: a load updates the stores, a run predicts its results.
            if (s_tvalid && s_tready) begin
                ld_row    = s_tdata[ROW_W-1:0];
                ld_col    = s_tdata[ROW_W+COL_W-1:ROW_W];
                ld_amount = s_tdata[ROW_W+COL_W +: AMOUNT_W];
                case (t_bsc_action'(s_tuser))
                    ACT_LOAD_ALLOC: alloc_mem[ld_row][ld_col] = ld_amount;
                    ACT_LOAD_CLAIM: claim_mem[ld_row][ld_col] = ld_amount;
                    ACT_LOAD_AVAIL: avail_mem[ld_col] = ld_amount;
                    ACT_RUN:        predict_safety();
                    default: ;
                endcase
            end
            // Result transaction: compare against the oldest prediction.
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result with nothing expected: proc_index %0d is_safe %0b last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    o_fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (m_tdata !== OUT_DATA_W'(want.proc_index)) begin
                        $display("%0t: proc_index mismatch: expected %0d, actual %0d",
                                 $time, want.proc_index, m_tdata);
                        o_fail_count++;
                    end
                    if (m_tuser !== want.is_safe) begin
                        $display("%0t: is_safe mismatch: expected %0b, actual %0b",
                                 $time, want.is_safe, m_tuser);
                        o_fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_tlast);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = result_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus and verdict for the Banker's safety check unit.
module tb_top;
    import bsc_pkg::*;

    localparam int NPROC         = BSC_MAX_PROCS;
    localparam int NRES          = BSC_MAX_RES;
    localparam int TARGET_ITEMS  = 160;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 10000000;

    // Register indexes past the end of the register list.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int { FILL_SMALL, FILL_LARGE, FILL_WILD } t_fill_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic [1:0]            s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int pending;
    int fail_count;
    int rx_gap     = 0;
    int cycle_cnt  = 0;
    int items_sent = 0;
    int np_use     = NPROC;
    int nr_use     = NRES;
    bit tx_idle    = 1'b1;
    bit rx_idle    = 1'b1;
    bit rx_hs      = 1'b0;

    // Which store entries have been loaded since reset.
    bit alloc_set [NPROC][NRES];
    bit claim_set [NPROC][NRES];
    bit avail_set [NRES];

    bankers_safety_check_unit i_dut (.*);

    bsc_result_checker i_checker (.*, .o_pending(pending), .o_fail_count(fail_count));

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: when idling is on, hold tready low for a drawn gap after each transaction.
    always @(posedge i_clk) rx_hs <= m_tvalid && m_tready;

    always @(negedge i_clk) begin
        if (rx_hs) rx_gap = rx_idle ? $urandom_range(0, 9) : 0;
        if (!i_rst_n || rx_gap != 0) begin
            m_tready = 1'b0;
            if (rx_gap != 0) rx_gap--;
        end else begin
            m_tready = 1'b1;
        end
    end

    // Presents one input transaction, after a drawn gap when idling is on, and waits for its handshake.
    task automatic send_item(input t_bsc_action act, input int row, input int col, input int amt);
        logic [ROW_W-1:0]    row_f;
        logic [COL_W-1:0]    col_f;
        logic [AMOUNT_W-1:0] amt_f;
        int                  gap;
        row_f = row[ROW_W-1:0];
        col_f = col[COL_W-1:0];
        amt_f = amt[AMOUNT_W-1:0];
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {amt_f, col_f, row_f};
        do @(posedge i_clk); while (!s_tready);
        case (act)
            ACT_LOAD_ALLOC: alloc_set[row_f][col_f] = 1'b1;
            ACT_LOAD_CLAIM: claim_set[row_f][col_f] = 1'b1;
            ACT_LOAD_AVAIL: avail_set[col_f] = 1'b1;
            default: ;
        endcase
        items_sent++;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Waits until every predicted result has arrived and the unit has gone quiet.
    task automatic settle();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Loads any in-use entry still unwritten, then issues a run with random don't-care fields.
    task automatic fill_and_run();
        for (int p = 0; p < np_use; p++) begin
            for (int r = 0; r < nr_use; r++) begin
                if (!alloc_set[p][r]) send_item(ACT_LOAD_ALLOC, p, r, $urandom_range(0, 5));
                if (!claim_set[p][r]) send_item(ACT_LOAD_CLAIM, p, r, $urandom_range(0, 5));
            end
        end
        for (int r = 0; r < nr_use; r++) begin
            if (!avail_set[r]) send_item(ACT_LOAD_AVAIL, $urandom_range(0, 15), r, $urandom_range(0, 3));
        end
        send_item(ACT_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 65535));
    endtask

    // A value within spread of base, held to the amount range.
    function automatic int near_value(int base, int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v;
    endfunction

    // Raw register value for a count, sometimes zero for a count of one or out of range where it saturates.
    function automatic logic [CFG_DATA_W-1:0] raw_count(int n, int limit);
        if (n == 1 && $urandom_range(0, 1) == 1) return '0;
        if (n == limit && $urandom_range(0, 1) == 1) begin
            return CFG_DATA_W'($urandom_range(limit + 1, 31));
        end
        return n[CFG_DATA_W-1:0];
    endfunction

    // Picks the sizes of a phase and writes them while the unit is idle.
    task automatic configure_phase(input int phase);
        int sel;
        logic [CFG_DATA_W-1:0] raw_p;
        logic [CFG_DATA_W-1:0] raw_r;
        sel = $urandom_range(0, 9);
        if (phase == 0) begin
            np_use = NPROC;
            nr_use = 1;
        end else if (phase == 1) begin
            np_use = 1;
            nr_use = NRES;
        end else if (sel < 6) begin
            np_use = $urandom_range(1, 5);
            nr_use = $urandom_range(1, 4);
        end else if (sel == 6) begin
            np_use = NPROC;
            nr_use = $urandom_range(1, 2);
        end else if (sel == 7) begin
            np_use = $urandom_range(1, 2);
            nr_use = NRES;
        end else if (sel == 8) begin
            np_use = $urandom_range(6, 10);
            nr_use = $urandom_range(2, 3);
        end else begin
            np_use = $urandom_range(1, 8);
            nr_use = $urandom_range(5, 8);
        end
        raw_p = raw_count(np_use, NPROC);
        raw_r = raw_count(nr_use, NRES);
        settle();
        if ($urandom_range(0, 1) == 1) begin
            write_cfg(CFG_NUM_PROCS, raw_p);
            write_cfg(CFG_NUM_RES, raw_r);
        end else begin
            write_cfg(CFG_NUM_RES, raw_r);
            write_cfg(CFG_NUM_PROCS, raw_p);
        end
        if ($urandom_range(0, 4) == 0) begin
            write_cfg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      CFG_DATA_W'($urandom_range(0, 31)));
        end
    endtask

    // One scenario: a full reload, a few entry updates or nothing, at times some stray loads, then a run.
    task automatic run_scenario();
        int         kind;
        int         pick;
        int         a;
        int         c;
        t_fill_mode mode;
        kind = $urandom_range(0, 9);
        pick = $urandom_range(0, 5);
        mode = (pick < 3) ? FILL_SMALL : (pick < 5) ? FILL_LARGE : FILL_WILD;
        if (kind < 4) begin
            for (int p = 0; p < np_use; p++) begin
                for (int r = 0; r < nr_use; r++) begin
                    a = (mode == FILL_SMALL) ? $urandom_range(0, 6) : $urandom_range(0, 65535);
                    c = (mode == FILL_WILD) ? $urandom_range(0, 65535) : near_value(a, 3);
                    send_item(ACT_LOAD_ALLOC, p, r, a);
                    send_item(ACT_LOAD_CLAIM, p, r, c);
                end
            end
            for (int r = 0; r < nr_use; r++) begin
                a = (mode == FILL_SMALL) ? $urandom_range(0, 3) :
                    (mode == FILL_LARGE) ? $urandom_range(0, 8) : $urandom_range(0, 65535);
                send_item(ACT_LOAD_AVAIL, $urandom_range(0, 15), r, a);
            end
        end else if (kind < 9) begin
            repeat ($urandom_range(1, 4)) begin
                send_item(t_bsc_action'($urandom_range(0, 2)), $urandom_range(0, np_use - 1),
                          $urandom_range(0, nr_use - 1), $urandom_range(0, 6));
            end
        end
        // Stray loads anywhere in the stores, including rows and columns not in use.
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_item(t_bsc_action'($urandom_range(0, 2)), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 65535));
            end
        end
        fill_and_run();
    endtask

    initial begin
        int phase;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Single process, single resource; zero counts act as one.
        write_cfg(CFG_NUM_PROCS, '0);
        write_cfg(CFG_NUM_RES, '0);
        write_cfg(CFG_SPARE_LO, 5'd31);
        write_cfg(CFG_SPARE_HI, 5'd1);
        np_use = 1;
        nr_use = 1;
        // Need of exactly zero against zero available.
        send_item(ACT_LOAD_ALLOC, 0, 0, 16'hFFFF);
        send_item(ACT_LOAD_CLAIM, 0, 0, 16'hFFFF);
        send_item(ACT_LOAD_AVAIL, 15, 0, 0);
        fill_and_run();
        // Negative need always fits.
        send_item(ACT_LOAD_CLAIM, 0, 0, 0);
        fill_and_run();
        // Need one above what is available: unsafe.
        send_item(ACT_LOAD_ALLOC, 0, 0, 0);
        send_item(ACT_LOAD_CLAIM, 0, 0, 16'hFFFF);
        send_item(ACT_LOAD_AVAIL, 0, 0, 16'hFFFE);
        fill_and_run();
        // Loads beyond the counts in use are stored but leave the run unchanged.
        send_item(ACT_LOAD_ALLOC, 15, 15, 16'hA5A5);
        send_item(ACT_LOAD_AVAIL, 7, 15, 16'h5A5A);
        fill_and_run();

        // Two processes: the second finishes on the first pass, the first only on the second pass.
        settle();
        write_cfg(CFG_NUM_PROCS, 5'd2);
        write_cfg(CFG_NUM_RES, 5'd2);
        np_use = 2;
        nr_use = 2;
        send_item(ACT_LOAD_ALLOC, 0, 0, 0);
        send_item(ACT_LOAD_ALLOC, 0, 1, 0);
        send_item(ACT_LOAD_ALLOC, 1, 0, 1);
        send_item(ACT_LOAD_ALLOC, 1, 1, 1);
        send_item(ACT_LOAD_CLAIM, 0, 0, 2);
        send_item(ACT_LOAD_CLAIM, 0, 1, 2);
        send_item(ACT_LOAD_CLAIM, 1, 0, 1);
        send_item(ACT_LOAD_CLAIM, 1, 1, 2);
        send_item(ACT_LOAD_AVAIL, 0, 0, 1);
        send_item(ACT_LOAD_AVAIL, 0, 1, 1);
        fill_and_run();

        // Random phases; the first two take the extreme sizes of each register.
        phase = 0;
        while (phase < 2 || items_sent < TARGET_ITEMS) begin
            configure_phase(phase);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4)) begin
                if (phase < 2 || items_sent < TARGET_ITEMS) run_scenario();
            end
            phase++;
        end

        settle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== bankers_safety_check_unit.f =====
rtl/core/bsc_pkg.sv
rtl/core/bsc_ctrl.sv
rtl/core/bsc_datapath.sv
rtl/core/bankers_safety_check_unit.sv
tb/bsc_result_checker.sv
tb/tb_top.sv
